// File: design/nalgop_pkg.sv
`default_nettype none

package nalgop_pkg;

   localparam int POSITION_BITS = 32;
   localparam int COUNT_BITS    = 32;
   localparam int NUM_SLOTS     = 4;
   localparam int FIFO_DEPTH    = 4;
   localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
   localparam int LEVEL_BITS    = $clog2(FIFO_DEPTH + 1);
   localparam int RSP_DATA_BITS = 144;

   localparam logic [7:0] START_BYTE      = 8'h01;
   localparam logic [5:0] TYPE_IDR_H264   = 6'd5;
   localparam logic [5:0] TYPE_P_H264     = 6'd1;
   localparam logic [5:0] TYPE_IDR_HEVC   = 6'd19;
   localparam logic [5:0] TYPE_P_HEVC_MAX = 6'd1;

   typedef logic [POSITION_BITS-1:0] pos_type;

   typedef enum logic {
      CODEC_H264 = 1'b0,
      CODEC_HEVC = 1'b1
   } codec_type;

   typedef enum logic {
      REC_NAL     = 1'b0,
      REC_GOP_END = 1'b1
   } rec_kind_type;

   typedef enum logic [1:0] {
      FK_NONE = 2'd0,
      FK_P    = 2'd1,
      FK_IDR  = 2'd2
   } frame_kind_type;

   typedef struct packed {
      rec_kind_type   kind;
      logic [31:0]    offset;
      logic [31:0]    size;
      logic [5:0]     nal_type;
      frame_kind_type frame_kind;
      logic [31:0]    frame_number;
      logic           gop_begins;
      logic [31:0]    gop_frame_count;
      logic           last;
   } rec_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] valid;
      rec_type [NUM_SLOTS-1:0] rec;
   } push_type;

endpackage

`default_nettype wire

// File: design/nalgop_scan.sv
`default_nettype none

module nalgop_scan
   import nalgop_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [7:0]  in_byte,
   input  wire logic        in_eos,
   input  wire logic        space,
   output push_type         push
);

   typedef struct packed {
      logic                  emit;
      frame_kind_type        cls;
      logic                  opens;
      logic                  nfy;
      logic [COUNT_BITS-1:0] gop;
      logic [COUNT_BITS-1:0] cnt;
   } cf_type;

   function automatic cf_type count_frame(input logic [5:0] t, input codec_type codec,
                                          input logic nfy, input logic [COUNT_BITS-1:0] gop,
                                          input logic [COUNT_BITS-1:0] cnt);
      cf_type r;
      logic   idr;
      logic   pf;
      idr = (codec == CODEC_HEVC) ? (t == TYPE_IDR_HEVC) : (t == TYPE_IDR_H264);
      pf  = (codec == CODEC_HEVC) ? (t <= TYPE_P_HEVC_MAX) : (t == TYPE_P_H264);
      r.emit  = 1'b0;
      r.cls   = FK_NONE;
      r.opens = 1'b0;
      r.nfy   = nfy;
      r.gop   = gop;
      r.cnt   = cnt;
      if (idr || pf) begin
         if (idr || nfy) begin
            r.emit  = !nfy;
            r.gop   = '0;
            r.nfy   = 1'b0;
            r.opens = 1'b1;
         end
         r.cls = idr ? FK_IDR : FK_P;
         r.cnt = cnt + 1'b1;
         r.gop = r.gop + 1'b1;
      end
      return r;
   endfunction

   function automatic rec_type nal_rec(input pos_type start, input pos_type size,
                                       input logic [5:0] t, input frame_kind_type cls,
                                       input logic [COUNT_BITS-1:0] cnt, input logic opens);
      rec_type r;
      r.kind            = REC_NAL;
      r.offset          = 32'(start);
      r.size            = 32'(size);
      r.nal_type        = t;
      r.frame_kind      = cls;
      r.frame_number    = (cls != FK_NONE) ? 32'(cnt - 1'b1) : '0;
      r.gop_begins      = (cls != FK_NONE) ? opens : 1'b0;
      r.gop_frame_count = '0;
      r.last            = 1'b0;
      return r;
   endfunction

   function automatic rec_type gop_rec(input logic [COUNT_BITS-1:0] gop);
      rec_type r;
      r                 = '0;
      r.kind            = REC_GOP_END;
      r.frame_kind      = FK_NONE;
      r.gop_frame_count = 32'(gop);
      return r;
   endfunction

   codec_type             codec_ff;
   logic                  in_valid_ff;
   logic [7:0]            byte_ff;
   logic                  eos_ff;

   logic [23:0]           hist_ff,    hist_in;
   logic [1:0]            hcnt_ff,    hcnt_in;
   pos_type               pos_ff,     pos_in;
   pos_type               start_ff,   start_in;
   logic [2:0]            clen_ff,    clen_in;
   logic                  inside_ff,  inside_in;
   logic [5:0]            htype_ff,   htype_in;
   logic                  hseen_ff,   hseen_in;
   frame_kind_type        cls_ff,     cls_in;
   logic                  opens_ff,   opens_in;
   logic [COUNT_BITS-1:0] cnt_ff,     cnt_in;
   logic [COUNT_BITS-1:0] gop_ff,     gop_in;
   logic                  nfy_ff,     nfy_in;

   logic                  step;
   logic [5:0]            hdr_type;
   logic                  a_do;
   cf_type                cf_a;
   cf_type                cf_c;
   logic [5:0]            htype_a;
   logic                  hseen_a;
   frame_kind_type        cls_a;
   logic                  opens_a;
   logic                  nfy_a;
   logic [COUNT_BITS-1:0] gop_a;
   logic [COUNT_BITS-1:0] cnt_a;
   logic                  len4;
   logic                  len3;
   logic                  code_found;
   logic [2:0]            clen_new;
   pos_type               code_pos;
   pos_type               start_b;
   logic [2:0]            clen_b;
   logic                  inside_b;
   logic                  hseen_b;
   logic [5:0]            htype_b;
   frame_kind_type        cls_b;
   logic                  opens_b;
   logic                  c_cnt;
   frame_kind_type        cls_c;
   logic                  opens_c;
   logic                  nfy_c;
   logic [COUNT_BITS-1:0] gop_c;
   logic [COUNT_BITS-1:0] cnt_c;
   pos_type               pos_next;
   pos_type               size_b;
   pos_type               size_c;
   logic [NUM_SLOTS-1:0]  v;

   assign step     = in_valid_ff && space;
   assign in_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff    <= CODEC_H264;
         in_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            codec_ff <= codec_type'(csr_wr_data);
         end
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         eos_ff  <= in_eos;
      end
   end

   // header byte, start-code check, end-of-stream close
   always_comb begin
      hdr_type = (codec_ff == CODEC_HEVC) ? byte_ff[6:1] : {1'b0, byte_ff[4:0]};
      a_do     = inside_ff && !hseen_ff;
      cf_a     = count_frame(hdr_type, codec_ff, nfy_ff, gop_ff, cnt_ff);
      htype_a  = a_do ? hdr_type : htype_ff;
      hseen_a  = hseen_ff || a_do;
      cls_a    = a_do ? cf_a.cls   : cls_ff;
      opens_a  = a_do ? cf_a.opens : opens_ff;
      nfy_a    = a_do ? cf_a.nfy   : nfy_ff;
      gop_a    = a_do ? cf_a.gop   : gop_ff;
      cnt_a    = a_do ? cf_a.cnt   : cnt_ff;

      len4 = (byte_ff == START_BYTE) && (hcnt_ff == 2'd3) && (hist_ff == 24'h0);
      len3 = !len4 && (byte_ff == START_BYTE) && (hcnt_ff >= 2'd2) &&
             (hist_ff[15:0] == 16'h0) && !eos_ff;
      code_found = len4 || len3;
      clen_new   = len4 ? 3'd4 : 3'd3;
      code_pos   = pos_ff - (len4 ? pos_type'(3) : pos_type'(2));
      size_b     = code_pos - start_ff - pos_type'(clen_ff);

      start_b  = code_found ? code_pos : start_ff;
      clen_b   = code_found ? clen_new : clen_ff;
      inside_b = inside_ff || code_found;
      hseen_b  = code_found ? 1'b0    : hseen_a;
      htype_b  = code_found ? 6'd0    : htype_a;
      cls_b    = code_found ? FK_NONE : cls_a;
      opens_b  = code_found ? 1'b0    : opens_a;

      // empty payload at end of stream: judged as type 0
      cf_c    = count_frame(6'd0, codec_ff, nfy_a, gop_a, cnt_a);
      c_cnt   = inside_b && !hseen_b;
      cls_c   = c_cnt ? cf_c.cls   : cls_b;
      opens_c = c_cnt ? cf_c.opens : opens_b;
      nfy_c   = c_cnt ? cf_c.nfy   : nfy_a;
      gop_c   = c_cnt ? cf_c.gop   : gop_a;
      cnt_c   = c_cnt ? cf_c.cnt   : cnt_a;

      pos_next = pos_ff + 1'b1;
      size_c   = pos_next - start_b - pos_type'(clen_b);

      v[0] = step && a_do && cf_a.emit;
      v[1] = step && code_found && inside_ff;
      v[2] = step && eos_ff && inside_b;
      v[3] = step && eos_ff && !nfy_c;

      push.valid  = v;
      push.rec[0] = gop_rec(gop_ff);
      push.rec[1] = nal_rec(start_ff, size_b, htype_a, cls_a, cnt_a, opens_a);
      push.rec[2] = nal_rec(start_b, size_c, htype_b, cls_c, cnt_c, opens_c);
      push.rec[3] = gop_rec(gop_c);
      push.rec[0].last = !(v[1] || v[2] || v[3]);
      push.rec[1].last = !(v[2] || v[3]);
      push.rec[2].last = !v[3];
      push.rec[3].last = 1'b1;

      if (eos_ff) begin
         hist_in   = '0;
         hcnt_in   = '0;
         pos_in    = '0;
         start_in  = '0;
         clen_in   = '0;
         inside_in = 1'b0;
         htype_in  = '0;
         hseen_in  = 1'b0;
         cls_in    = FK_NONE;
         opens_in  = 1'b0;
         cnt_in    = '0;
         gop_in    = '0;
         nfy_in    = 1'b1;
      end else begin
         hist_in   = {hist_ff[15:0], byte_ff};
         hcnt_in   = code_found ? 2'd0 : ((hcnt_ff == 2'd3) ? 2'd3 : hcnt_ff + 2'd1);
         pos_in    = pos_next;
         start_in  = start_b;
         clen_in   = clen_b;
         inside_in = inside_b;
         htype_in  = htype_b;
         hseen_in  = hseen_b;
         cls_in    = cls_b;
         opens_in  = opens_b;
         cnt_in    = cnt_a;
         gop_in    = gop_a;
         nfy_in    = nfy_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         hcnt_ff   <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
         clen_ff   <= '0;
         inside_ff <= 1'b0;
         htype_ff  <= '0;
         hseen_ff  <= 1'b0;
         cls_ff    <= FK_NONE;
         opens_ff  <= 1'b0;
         cnt_ff    <= '0;
         gop_ff    <= '0;
         nfy_ff    <= 1'b1;
      end else if (step) begin
         hist_ff   <= hist_in;
         hcnt_ff   <= hcnt_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         clen_ff   <= clen_in;
         inside_ff <= inside_in;
         htype_ff  <= htype_in;
         hseen_ff  <= hseen_in;
         cls_ff    <= cls_in;
         opens_ff  <= opens_in;
         cnt_ff    <= cnt_in;
         gop_ff    <= gop_in;
         nfy_ff    <= nfy_in;
      end
   end

endmodule

`default_nettype wire

// File: design/nalgop_rec_fifo.sv
`default_nettype none

module nalgop_rec_fifo
   import nalgop_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      space,
   output logic      out_valid,
   input  wire logic out_ready,
   output rec_type   out_rec
);

   rec_type               mem_ff [FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff,  wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff,  rd_ptr_in;
   logic [LEVEL_BITS-1:0] level_ff,   level_in;
   logic [PTR_BITS-1:0]   waddr [NUM_SLOTS];
   logic [LEVEL_BITS-1:0] npush;
   logic                  pop;

   // pack the valid slots in order behind the write pointer
   always_comb begin
      npush = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         waddr[i] = PTR_BITS'(wr_ptr_ff + npush);
         npush    = npush + LEVEL_BITS'(push.valid[i]);
      end
   end

   assign out_valid = (level_ff != '0);
   assign out_rec   = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign space     = (level_ff <= LEVEL_BITS'(FIFO_DEPTH - 3));
   assign wr_ptr_in = PTR_BITS'(wr_ptr_ff + npush);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign level_in  = level_ff + npush - LEVEL_BITS'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (push.valid[i]) begin
            mem_ff[waddr[i]] <= push.rec[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

// File: design/annexb_nal_scanner_gop_splitter_top.sv
// Channel  Dir  Beat                       Payload
// req_     in   one stream byte            tdata: data_byte; tlast: end_of_stream
// rsp_     out  one NAL or GOP-end record  tuser: record_kind; tdata: see port
// csr_     in   codec_kind write           csr_wr_data
//
// One byte per clock while each byte yields at most one record and rsp_tready
// stays high; a byte that yields two or three records holds the input while
// the 4-entry record queue drains, one per clock while rsp_tready is high.
// A record passes through the input register and the queue before it can leave.
// The scanner steps only while the queue has room for three records.
// Synchronous active-high reset; codec_kind resets to H.264.
`default_nettype none

module annexb_nal_scanner_gop_splitter_top
   import nalgop_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic                     csr_wr_data,    // codec_kind
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [7:0]               req_tdata,      // data_byte
   input  wire logic                     req_tlast,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // nal_offset[31:0], nal_size[63:32], nal_type[69:64], frame_kind[71:70],
   // frame_number[103:72], gop_begins[104], gop_frame_count[136:105], zeros
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                          rsp_tuser,      // record_kind
   output logic                          rsp_tlast
);

   push_type push;
   logic     space;
   rec_type  rec;

   nalgop_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_byte     (req_tdata),
      .in_eos      (req_tlast),
      .space       (space),
      .push        (push)
   );

   nalgop_rec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (rec)
   );

   assign rsp_tuser = rec.kind;
   assign rsp_tlast = rec.last;
   assign rsp_tdata = {7'd0, rec.gop_frame_count, rec.gop_begins, rec.frame_number,
                       rec.frame_kind, rec.nal_type, rec.size, rec.offset};

endmodule

`default_nettype wire
